// File: hdl/byte_stack_with_rotate_macros.svh
// Assertion macros for the byte stack checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BYTE_STACK_WITH_ROTATE_MACROS_SVH
`define BYTE_STACK_WITH_ROTATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte stack checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define BSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte stack checker: next-cycle property failed");

`endif

// File: hdl/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int RDEPTH_W = 7;
	localparam int CAP_W    = 7;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_POP      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROT_UP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROT_DOWN = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd6;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// What every cell does in a cycle.
	typedef enum logic [2:0] {
		OP_HOLD,   // keep the byte
		OP_PUSH,   // take the byte from the cell above
		OP_POP,    // take the byte from the cell below
		OP_ROT,    // cells above pos take from below, cell pos takes the top
		OP_SWAP    // cells pos-1 and pos trade bytes
	} cell_op_t;

endpackage

`default_nettype wire

// File: hdl/bsr_cell.sv
`default_nettype none

module bsr_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  wire logic                          clk,
	input  wire bsr_pkg::cell_op_t             op,
	input  wire logic [PW-1:0]                 pos,
	input  wire logic [bsr_pkg::BYTE_W-1:0]    left_byte,
	input  wire logic [bsr_pkg::BYTE_W-1:0]    right_byte,
	input  wire logic [bsr_pkg::BYTE_W-1:0]    top_byte,
	output logic      [bsr_pkg::BYTE_W-1:0]    entry_q
);

	localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
	localparam logic [PW-1:0] MY_NEXT = PW'(IDX + 1);

	always_ff @(posedge clk) begin
		unique case (op)
			bsr_pkg::OP_PUSH: entry_q <= left_byte;
			bsr_pkg::OP_POP:  entry_q <= right_byte;
			bsr_pkg::OP_ROT: begin
				if (MY_IDX < pos) begin
					entry_q <= right_byte;
				end else if (MY_IDX == pos) begin
					entry_q <= top_byte;
				end
			end
			bsr_pkg::OP_SWAP: begin
				if (MY_IDX == pos) begin
					entry_q <= left_byte;
				end else if (MY_NEXT == pos) begin
					entry_q <= right_byte;
				end
			end
			default: entry_q <= entry_q;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/bsr_ctrl.sv
`default_nettype none

module bsr_ctrl #(
	parameter int STACK_DEPTH = 64,
	parameter int FW          = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [bsr_pkg::CMD_W-1:0]         cmd,
	input  wire logic [bsr_pkg::BYTE_W-1:0]        push_byte,
	input  wire logic [bsr_pkg::RDEPTH_W-1:0]      rotate_depth,
	input  wire logic                              cfg_we,
	input  wire logic [bsr_pkg::CAP_W-1:0]         cfg_wdata,
	input  wire logic [bsr_pkg::BYTE_W-1:0]        top_byte,
	output logic                                   busy,
	output logic                                   result_strobe,
	output logic      [bsr_pkg::STATUS_W-1:0]      status,
	output logic      [bsr_pkg::BYTE_W-1:0]        data_byte,
	output logic                                   data_valid,
	output logic                                   last_of_run,
	output bsr_pkg::cell_op_t                      cell_op,
	output logic      [FW-1:0]                     cell_pos,
	output logic      [bsr_pkg::BYTE_W-1:0]        cell_byte
);

	localparam int CW = (FW > bsr_pkg::RDEPTH_W) ? FW : bsr_pkg::RDEPTH_W;
	localparam logic [CW-1:0] DEPTH_C  = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ROT_MIN  = CW'(2);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DUMP = 2'd1;
	localparam logic [1:0] S_SWAP = 2'd2;

	logic [1:0]                     state_q, state_d;
	logic [FW-1:0]                  fill_q, fill_d;
	logic [FW-1:0]                  cnt_q, cnt_d;
	logic [bsr_pkg::CAP_W-1:0]      cap_q;

	logic [CW-1:0] cap_ext, eff_cap, fill_ext, rd_ext;
	logic          is_full, is_empty, rot_ok;

	logic                           res_v;
	logic [bsr_pkg::STATUS_W-1:0]   res_st;
	logic [bsr_pkg::BYTE_W-1:0]     res_d;
	logic                           res_dv, res_last;

	assign cap_ext  = CW'(cap_q);
	assign eff_cap  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
	assign fill_ext = CW'(fill_q);
	assign rd_ext   = CW'(rotate_depth);
	assign is_full  = (fill_ext >= eff_cap);
	assign is_empty = (fill_q == '0);
	assign rot_ok   = (rd_ext >= ROT_MIN) && (rd_ext <= fill_ext);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		cnt_d     = cnt_q;
		cell_op   = bsr_pkg::OP_HOLD;
		cell_pos  = '0;
		cell_byte = push_byte;
		res_v     = 1'b0;
		res_st    = bsr_pkg::STAT_OK;
		res_d     = '0;
		res_dv    = 1'b0;
		res_last  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_v = 1'b1;
					unique case (cmd)
						bsr_pkg::CMD_POP, bsr_pkg::CMD_PEEK: begin
							if (is_empty) begin
								res_st = bsr_pkg::STAT_EMPTY;
							end else begin
								res_d  = top_byte;
								res_dv = 1'b1;
								if (cmd == bsr_pkg::CMD_POP) begin
									cell_op = bsr_pkg::OP_POP;
									fill_d  = fill_q - FW'(1);
								end
							end
						end
						bsr_pkg::CMD_PUSH: begin
							if (is_full) begin
								res_st = bsr_pkg::STAT_FULL;
							end else begin
								cell_op = bsr_pkg::OP_PUSH;
								fill_d  = fill_q + FW'(1);
							end
						end
						bsr_pkg::CMD_DUP: begin
							if (is_full) begin
								res_st = bsr_pkg::STAT_FULL;
							end else if (is_empty) begin
								res_st = bsr_pkg::STAT_EMPTY;
							end else begin
								cell_op   = bsr_pkg::OP_PUSH;
								cell_byte = top_byte;
								fill_d    = fill_q + FW'(1);
							end
						end
						bsr_pkg::CMD_ROT_UP: begin
							if (rot_ok) begin
								cell_op  = bsr_pkg::OP_ROT;
								cell_pos = FW'(rd_ext - CW'(1));
							end
						end
						bsr_pkg::CMD_ROT_DOWN: begin
							if (rot_ok) begin
								state_d = S_SWAP;
								cnt_d   = FW'(rd_ext - CW'(1));
							end
						end
						bsr_pkg::CMD_DUMP: begin
							if (is_empty) begin
								res_st = bsr_pkg::STAT_EMPTY;
							end else begin
								res_v   = 1'b0;
								state_d = S_DUMP;
								cnt_d   = fill_q;
							end
						end
						default: begin
							res_st = bsr_pkg::STAT_OK;
						end
					endcase
				end
			end
			S_DUMP: begin
				// Show the top, then turn the filled part by one place.
				res_v    = 1'b1;
				res_d    = top_byte;
				res_dv   = 1'b1;
				res_last = (cnt_q == FW'(1));
				cell_op  = bsr_pkg::OP_ROT;
				cell_pos = fill_q - FW'(1);
				cnt_d    = cnt_q - FW'(1);
				if (cnt_q == FW'(1)) begin
					state_d = S_IDLE;
				end
			end
			S_SWAP: begin
				cell_op  = bsr_pkg::OP_SWAP;
				cell_pos = cnt_q;
				cnt_d    = cnt_q - FW'(1);
				if (cnt_q == FW'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			cnt_q         <= '0;
			cap_q         <= bsr_pkg::CAP_RESET;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			fill_q        <= fill_d;
			cnt_q         <= cnt_d;
			result_strobe <= res_v;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v) begin
			status      <= res_st;
			data_byte   <= res_d;
			data_valid  <= res_dv;
			last_of_run <= res_last;
		end
	end

endmodule

`default_nettype wire

// File: hdl/byte_stack_with_rotate.sv
// Channel        Signals                                   Handshake
// command        cmd, push_byte, rotate_depth              beat taken when start && !busy
// result         status, data_byte, data_valid,            one beat per cycle with
//                last_of_run                               result_strobe high
// capacity       cfg_wdata                                 written when cfg_we is high
//
// Push, pop, peek, duplicate, up-rotate, unused codes, an ignored down-rotate and a dump
// of an empty stack leave busy low: the result beat follows in the cycle after acceptance.
// A down-rotate of depth n with 2 <= n <= fill keeps busy high while it makes n-1 swaps.
// A dump of a stack holding f entries keeps busy high while it shows f beats, one per entry.
// Reset clears the fill count, sets capacity to 64; the byte cells have no reset.
// The receiver cannot stall: every result beat is taken in the cycle it is shown.
`default_nettype none

module byte_stack_with_rotate #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [bsr_pkg::CMD_W-1:0]         cmd,
	input  wire logic [bsr_pkg::BYTE_W-1:0]        push_byte,
	input  wire logic [bsr_pkg::RDEPTH_W-1:0]      rotate_depth,
	input  wire logic                              cfg_we,
	input  wire logic [bsr_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                                   result_strobe,
	output logic      [bsr_pkg::STATUS_W-1:0]      status,
	output logic      [bsr_pkg::BYTE_W-1:0]        data_byte,
	output logic                                   data_valid,
	output logic                                   last_of_run
);

	localparam int FW = $clog2(STACK_DEPTH + 1);

	// The stack lives in a row of cells; cell 0 holds the top entry and cell i
	// holds the entry i places below it. Every cycle all cells obey one shared
	// operation and trade bytes only with neighbors, except that the top cell
	// takes pushed bytes and a rotate drops the top byte at its position.
	bsr_pkg::cell_op_t             cell_op;
	logic [FW-1:0]                 cell_pos;
	logic [bsr_pkg::BYTE_W-1:0]    cell_byte;
	logic [bsr_pkg::BYTE_W-1:0]    entries [STACK_DEPTH];

	bsr_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.FW          (FW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.push_byte     (push_byte),
		.rotate_depth  (rotate_depth),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.top_byte      (entries[0]),
		.busy          (busy),
		.result_strobe (result_strobe),
		.status        (status),
		.data_byte     (data_byte),
		.data_valid    (data_valid),
		.last_of_run   (last_of_run),
		.cell_op       (cell_op),
		.cell_pos      (cell_pos),
		.cell_byte     (cell_byte)
	);

	for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
		logic [bsr_pkg::BYTE_W-1:0] left_b, right_b;

		// The top cell is fed the pushed byte; the bottom cell sees itself below.
		if (gi == 0) begin : g_first
			assign left_b = cell_byte;
		end else begin : g_inner_l
			assign left_b = entries[gi-1];
		end
		if (gi == STACK_DEPTH - 1) begin : g_last
			assign right_b = entries[gi];
		end else begin : g_inner_r
			assign right_b = entries[gi+1];
		end

		bsr_cell #(
			.IDX (gi),
			.PW  (FW)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.pos        (cell_pos),
			.left_byte  (left_b),
			.right_byte (right_b),
			.top_byte   (entries[0]),
			.entry_q    (entries[gi])
		);
	end

endmodule

`default_nettype wire

// File: hdl/bsr_checker.sv
`default_nettype none
`include "byte_stack_with_rotate_macros.svh"

module bsr_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic [bsr_pkg::CMD_W-1:0]         cmd,
	input wire logic                              result_strobe,
	input wire logic [bsr_pkg::STATUS_W-1:0]      status,
	input wire logic [bsr_pkg::BYTE_W-1:0]        data_byte,
	input wire logic                              data_valid,
	input wire logic                              last_of_run
);

	// Every command other than a dump answers with a single final beat next cycle.
	`BSR_ASSERT_NEXT(a_single_beat, start && !busy && cmd != bsr_pkg::CMD_DUMP, result_strobe && last_of_run)

	// A beat carrying a stack entry always reports success.
	`BSR_ASSERT_NOW(a_valid_ok, result_strobe && data_valid, status == bsr_pkg::STAT_OK)

	// Without an entry the data byte reads zero.
	`BSR_ASSERT_NOW(a_zero_data, result_strobe && !data_valid, data_byte == '0)

	// An empty report always closes its command.
	`BSR_ASSERT_NOW(a_empty_last, result_strobe && status == bsr_pkg::STAT_EMPTY, last_of_run)

endmodule

bind byte_stack_with_rotate bsr_checker u_bsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cmd           (cmd),
	.result_strobe (result_strobe),
	.status        (status),
	.data_byte     (data_byte),
	.data_valid    (data_valid),
	.last_of_run   (last_of_run)
);

`default_nettype wire
